### design/mmb_pkg.sv
// ----------------------------------------------------------------------------
// mmb_pkg
// Shared types, constants and the sine generator used to fill the trig ROM.
// ----------------------------------------------------------------------------
package mmb_pkg;

    // 360 degrees with 8 fraction bits
    localparam int unsigned TURN_UNITS = 92160;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [31:0] QUARTER_PHASE = 32'h4000_0000;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic [1:0] LAST_ROW = 2'd3;
    localparam logic [1:0] FIRST_ROW = 2'd0;

    // Side payload that rides along with the angles
    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] scale;
    } side_t;

    // Table sine and cosine, Q16.16 in [-1, 1]
    typedef struct packed {
        logic signed [17:0] sin_z;
        logic signed [17:0] cos_z;
        logic signed [17:0] sin_a;
        logic signed [17:0] cos_a;
    } trig_t;

    // Finished upper 3x3 block plus the x translation
    typedef struct packed {
        logic [2:0][2:0][31:0] elem;
        logic signed [31:0]    shift_x;
    } mat_t;

    // Taylor divisors (2i)(2i+1) for i = 1..6
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // Q16.16 sine at a 32-bit phase; used only to build constant tables
    function automatic logic signed [17:0] phase_sin(input logic [31:0] p);
        logic [1:0]         q;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        q = p[31:30];
        r = {34'd0, p[29:0]};
        if (q[0]) begin
            r = (64'd1 << 30) - r;
        end
        x = (r * HALF_PI_Q30) >> 30;
        term = x;
        sum = signed'(x);
        for (int i = 0; i < 6; i++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[i];
            if (i % 2 == 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        v = (sum < 0) ? 64'sd0 : sum;
        v = (v + 64'sd8192) >>> 14;
        if (v > 64'sd65536) begin
            v = 64'sd65536;
        end
        return q[1] ? -18'(v) : 18'(v);
    endfunction

endpackage

### design/mmb_angle.sv
// ----------------------------------------------------------------------------
// mmb_angle
// Reduce both angles modulo one turn, round to a table index, read sin/cos.
// ----------------------------------------------------------------------------
module mmb_angle #(
    parameter int DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [23:0]    z_angle,
    input  logic signed [23:0]    axis_angle,
    input  mmb_pkg::side_t        side_in,
    output logic                  out_valid,
    output mmb_pkg::trig_t        trig_out,
    output mmb_pkg::side_t        side_out
);
    localparam int KW    = $clog2(DEPTH);
    localparam int NUM_W = $clog2(mmb_pkg::TURN_UNITS * DEPTH);
    localparam int NST   = 7;
    localparam logic [24:0] OFFSET = 25'(92 * mmb_pkg::TURN_UNITS);
    localparam logic [23:0] RECIP_T = 24'((64'd1 << 40) / 64'(mmb_pkg::TURN_UNITS));
    localparam logic [31:0] RECIP_K = 32'((64'd1 << 48) / 64'(mmb_pkg::TURN_UNITS));

    // constant trig tables
    logic signed [17:0] sin_rom [DEPTH];
    logic signed [17:0] cos_rom [DEPTH];
    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        localparam logic [63:0] PH = (64'(g) << 32) / 64'(DEPTH);
        assign sin_rom[g] = mmb_pkg::phase_sin(PH[31:0]);
        assign cos_rom[g] = mmb_pkg::phase_sin(PH[31:0] + mmb_pkg::QUARTER_PHASE);
    end

    logic [NST-1:0]          v_reg;
    mmb_pkg::side_t          sd_reg [NST];
    logic [24:0]             a1_reg [2];
    logic [24:0]             a2_reg [2];
    logic [7:0]              q2_reg [2];
    logic [17:0]             m0_reg [2];
    logic [NUM_W-1:0]        num_reg [2];
    logic [NUM_W-1:0]        num5_reg [2];
    logic [KW:0]             qk_reg [2];
    logic [KW-1:0]           k_reg [2];
    logic signed [17:0]      sin_reg [2];
    logic signed [17:0]      cos_reg [2];

    logic [24:0]             a_next [2];
    logic [48:0]             p1 [2];
    logic [17:0]             m0_next [2];
    logic [16:0]             m [2];
    logic [NUM_W-1:0]        num_next [2];
    logic [NUM_W+31:0]       p2 [2];
    logic [NUM_W:0]          rem [2];
    logic [KW:0]             kr [2];
    logic [KW-1:0]           k_next [2];

    always_comb begin
        a_next[0] = 25'(z_angle) + OFFSET;
        a_next[1] = 25'(axis_angle) + OFFSET;
        for (int l = 0; l < 2; l++) begin
            p1[l]      = 49'(a1_reg[l]) * 49'(RECIP_T);
            m0_next[l] = 18'(26'(a2_reg[l]) - 26'(q2_reg[l]) * 26'(mmb_pkg::TURN_UNITS));
            m[l]       = (m0_reg[l] >= 18'(mmb_pkg::TURN_UNITS))
                       ? 17'(m0_reg[l] - 18'(mmb_pkg::TURN_UNITS)) : m0_reg[l][16:0];
            num_next[l] = NUM_W'(m[l]) * NUM_W'(DEPTH) + NUM_W'(mmb_pkg::TURN_UNITS / 2);
            p2[l]      = (NUM_W+32)'(num_reg[l]) * (NUM_W+32)'(RECIP_K);
            rem[l]     = (NUM_W+1)'(num5_reg[l])
                       - (NUM_W+1)'(qk_reg[l]) * (NUM_W+1)'(mmb_pkg::TURN_UNITS);
            kr[l]      = (rem[l] >= (NUM_W+1)'(mmb_pkg::TURN_UNITS)) ? qk_reg[l] + 1'b1
                                                                      : qk_reg[l];
            k_next[l]  = (kr[l] >= (KW+1)'(DEPTH)) ? '0 : kr[l][KW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= side_in;
            for (int s = 1; s < NST; s++) begin
                sd_reg[s] <= sd_reg[s-1];
            end
            for (int l = 0; l < 2; l++) begin
                a1_reg[l]   <= a_next[l];
                a2_reg[l]   <= a1_reg[l];
                q2_reg[l]   <= p1[l][47:40];
                m0_reg[l]   <= m0_next[l];
                num_reg[l]  <= num_next[l];
                num5_reg[l] <= num_reg[l];
                qk_reg[l]   <= p2[l][48 +: KW+1];
                k_reg[l]    <= k_next[l];
                sin_reg[l]  <= sin_rom[k_reg[l]];
                cos_reg[l]  <= cos_rom[k_reg[l]];
            end
        end
    end

    assign out_valid      = v_reg[NST-1];
    assign side_out       = sd_reg[NST-1];
    assign trig_out.sin_z = sin_reg[0];
    assign trig_out.cos_z = cos_reg[0];
    assign trig_out.sin_a = sin_reg[1];
    assign trig_out.cos_a = cos_reg[1];

endmodule

### design/mmb_rot.sv
// ----------------------------------------------------------------------------
// mmb_rot
// Build the axis rotation, apply the Z rotation and scale, saturate.
// ----------------------------------------------------------------------------
module mmb_rot (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  mmb_pkg::trig_t  trig_in,
    input  mmb_pkg::side_t  side_in,
    output logic            out_valid,
    output mmb_pkg::mat_t   mat_out
);
    localparam int NST = 7;

    logic [NST-1:0]       v_reg;
    mmb_pkg::side_t       sd_reg [NST];
    mmb_pkg::trig_t       tr_reg [3];

    // stage 1
    logic signed [31:0]   nn_reg [3][3];
    logic signed [33:0]   sn_reg [3];
    logic signed [18:0]   omc_reg;
    // stage 2
    logic signed [20:0]   t_reg [3][3];
    logic signed [19:0]   sk_reg [3];
    // stage 3
    logic signed [21:0]   rr_reg [3][3];
    // stage 4
    logic signed [39:0]   pc_reg [3][2];
    logic signed [39:0]   ps_reg [3][2];
    logic signed [21:0]   r2_reg [3];
    // stage 5
    logic signed [23:0]   q_reg [3][3];
    // stage 6
    logic signed [55:0]   qs_reg [3][3];
    // stage 7
    logic [31:0]          res_reg [3][3];

    logic signed [15:0]   n [3];
    logic signed [50:0]   tw [3][3];
    logic signed [33:0]   skw [3];
    logic signed [19:0]   skm [3][3];
    logic signed [40:0]   qw [3][2];
    logic signed [55:0]   rw [3][3];
    logic signed [39:0]   rs [3][3];

    always_comb begin
        n[0] = side_in.axis_x;
        n[1] = side_in.axis_y;
        n[2] = side_in.axis_z;
        for (int i = 0; i < 3; i++) begin
            skw[i] = sn_reg[i] + 34'sd8192;
            for (int j = 0; j < 3; j++) begin
                tw[i][j] = 51'(omc_reg) * 51'(nn_reg[i][j]) + (51'sd1 <<< 27);
                rw[i][j] = qs_reg[i][j] + (56'sd1 <<< 15);
                rs[i][j] = 40'(rw[i][j] >>> 16);
            end
        end
        // skew part of the Rodrigues form
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                skm[i][j] = '0;
            end
        end
        skm[0][1] = -sk_reg[2];
        skm[0][2] =  sk_reg[1];
        skm[1][0] =  sk_reg[2];
        skm[1][2] = -sk_reg[0];
        skm[2][0] = -sk_reg[1];
        skm[2][1] =  sk_reg[0];
        for (int i = 0; i < 3; i++) begin
            qw[i][0] = 41'(pc_reg[i][0]) + 41'(ps_reg[i][1]) + 41'sd32768;
            qw[i][1] = 41'(pc_reg[i][1]) - 41'(ps_reg[i][0]) + 41'sd32768;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= side_in;
            tr_reg[0] <= trig_in;
            for (int s = 1; s < NST; s++) begin
                sd_reg[s] <= sd_reg[s-1];
            end
            for (int s = 1; s < 3; s++) begin
                tr_reg[s] <= tr_reg[s-1];
            end
            omc_reg <= 19'(mmb_pkg::ONE_Q16) - 19'(trig_in.cos_a);
            for (int i = 0; i < 3; i++) begin
                sn_reg[i] <= 34'(trig_in.sin_a) * 34'(n[i]);
                sk_reg[i] <= 20'(skw[i] >>> 14);
                r2_reg[i] <= rr_reg[i][2];
                for (int j = 0; j < 3; j++) begin
                    nn_reg[i][j] <= 32'(n[i]) * 32'(n[j]);
                    t_reg[i][j]  <= 21'(tw[i][j] >>> 28);
                    rr_reg[i][j] <= 22'(t_reg[i][j]) + 22'(skm[i][j])
                                  + ((i == j) ? 22'(tr_reg[1].cos_a) : 22'sd0);
                    qs_reg[i][j] <= 56'(q_reg[i][j]) * 56'(sd_reg[4].scale);
                    if (rs[i][j] > 40'sd2147483647) begin
                        res_reg[i][j] <= 32'h7FFF_FFFF;
                    end else if (rs[i][j] < -40'sd2147483648) begin
                        res_reg[i][j] <= 32'h8000_0000;
                    end else begin
                        res_reg[i][j] <= rs[i][j][31:0];
                    end
                end
                for (int j = 0; j < 2; j++) begin
                    pc_reg[i][j] <= 40'(rr_reg[i][j]) * 40'(tr_reg[2].cos_z);
                    ps_reg[i][j] <= 40'(rr_reg[i][j]) * 40'(tr_reg[2].sin_z);
                    q_reg[i][j]  <= 24'(qw[i][j] >>> 16);
                end
                q_reg[i][2] <= 24'(r2_reg[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mat_out.elem[i][j] = res_reg[i][j];
            end
        end
        mat_out.shift_x = sd_reg[NST-1].shift_x;
    end
    assign out_valid = v_reg[NST-1];

endmodule

### design/mmb_rows.sv
// ----------------------------------------------------------------------------
// mmb_rows
// Hold one finished matrix and send it out row by row.
// ----------------------------------------------------------------------------
module mmb_rows (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mmb_pkg::mat_t   mat_in,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [135:0]    m_tdata,
    output logic            m_tlast
);
    mmb_pkg::mat_t  mat_reg;
    logic           full_reg;
    logic [1:0]     row_reg;
    logic [31:0]    c0, c1, c2, c3;

    assign in_ready = !full_reg || (m_tready && row_reg == mmb_pkg::LAST_ROW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            row_reg  <= mmb_pkg::FIRST_ROW;
        end else if (in_valid && in_ready) begin
            full_reg <= 1'b1;
            row_reg  <= mmb_pkg::FIRST_ROW;
        end else if (full_reg && m_tready) begin
            if (row_reg == mmb_pkg::LAST_ROW) begin
                full_reg <= 1'b0;
            end
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mat_reg <= mat_in;
        end
    end

    always_comb begin
        case (row_reg)
            2'd0: begin
                c0 = mat_reg.elem[0][0];
                c1 = mat_reg.elem[0][1];
                c2 = mat_reg.elem[0][2];
                c3 = mat_reg.shift_x;
            end
            2'd1: begin
                c0 = mat_reg.elem[1][0];
                c1 = mat_reg.elem[1][1];
                c2 = mat_reg.elem[1][2];
                c3 = '0;
            end
            2'd2: begin
                c0 = mat_reg.elem[2][0];
                c1 = mat_reg.elem[2][1];
                c2 = mat_reg.elem[2][2];
                c3 = '0;
            end
            default: begin
                c0 = '0;
                c1 = '0;
                c2 = '0;
                c3 = mmb_pkg::ONE_Q16;
            end
        endcase
    end

    assign m_tvalid = full_reg;
    assign m_tlast  = (row_reg == mmb_pkg::LAST_ROW);
    assign m_tdata  = {6'd0, c3, c2, c1, c0, row_reg};

endmodule

### design/model_matrix_builder.sv
// ----------------------------------------------------------------------------
// model_matrix_builder
// Model matrix T * Ra * Rz * S from two table-driven angles, sent as rows.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request per matrix on the s_ channel. Each request produces four
//   results on the m_ channel, rows 0..3 in order; m_tlast marks row 3.
//   Path: an accepted request passes 7 stages of angle reduction and
//   sine/cosine ROM read, 7 stages of rotation, Z rotation and scale
//   arithmetic and one row holding register before its first row is on m_tdata.
//   Throughput: set by the single result channel, which moves one row per
//   cycle while m_tready is high. The pipeline itself takes a request every
//   cycle while not frozen, so up to 14 requests queue inside while rows drain.
//   Stall: when m_tready is low the row register holds, the pipeline freezes
//   once its last stage is full, and s_tready drops; nothing is lost.
//   Reset (aresetn low, synchronous) clears all valid bits and the row
//   register; no request is in flight afterward.
// ----------------------------------------------------------------------------
module model_matrix_builder #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // z_angle, axis_angle, axis_x, axis_y, axis_z, shift_x, scale
    input  logic [159:0]   s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // row_index, col0, col1, col2, col3, zero pad
    output logic [135:0]   m_tdata,
    output logic           m_tlast
);
    mmb_pkg::side_t side_in;
    mmb_pkg::side_t side_mid;
    mmb_pkg::trig_t trig;
    mmb_pkg::mat_t  mat;
    logic           ang_valid;
    logic           rot_valid;
    logic           rows_ready;
    logic           en;

    // advance the whole pipeline unless its finished request cannot be handed off
    assign en       = !rot_valid || rows_ready;
    assign s_tready = en;

    assign side_in.axis_x  = s_tdata[63:48];
    assign side_in.axis_y  = s_tdata[79:64];
    assign side_in.axis_z  = s_tdata[95:80];
    assign side_in.shift_x = s_tdata[127:96];
    assign side_in.scale   = s_tdata[159:128];

    mmb_angle #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_angle (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .z_angle    (s_tdata[23:0]),
        .axis_angle (s_tdata[47:24]),
        .side_in    (side_in),
        .out_valid  (ang_valid),
        .trig_out   (trig),
        .side_out   (side_mid)
    );

    mmb_rot u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ang_valid),
        .trig_in   (trig),
        .side_in   (side_mid),
        .out_valid (rot_valid),
        .mat_out   (mat)
    );

    mmb_rows u_rows (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rot_valid),
        .in_ready (rows_ready),
        .mat_in   (mat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### verif/model_matrix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// model_matrix_checker
// Watches both stream channels of the model matrix builder, predicts the four
// rows of each accepted request and compares every returned row field by field.
// ----------------------------------------------------------------------------
module model_matrix_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [159:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic         m_tlast,
    output int           errors,
    output int           pending
);
    localparam int TRIG_DEPTH = 1024;

    typedef struct {
        longint val[6];
    } matrix_row_t;

    longint      sin_rom[TRIG_DEPTH];
    longint      cos_rom[TRIG_DEPTH];
    matrix_row_t rows_due[$];

    // sine over a quarter turn, Q30, Taylor series through x^13
    function automatic longint quarter_wave(longint unsigned r);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x = (r * mmb_pkg::HALF_PI_Q30) >> 30;
        term = x;
        sum = longint'(x);
        for (int i = 1; i <= 6; i++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) begin
                sum -= longint'(term);
            end else begin
                sum += longint'(term);
            end
        end
        return sum;
    endfunction

    // Q16.16 sine at a full-turn phase of 2^32
    function automatic longint sine_at(bit [31:0] p);
        longint unsigned r;
        longint          v;
        r = {34'd0, p[29:0]};
        if (p[30]) begin
            r = (64'd1 << 30) - r;
        end
        v = quarter_wave(r);
        if (v < 0) begin
            v = 0;
        end
        v = (v + 8192) >>> 14;
        if (v > 65536) begin
            v = 65536;
        end
        return p[31] ? -v : v;
    endfunction

    // nearest table slot for an angle in degrees with 8 fraction bits
    function automatic int table_slot(bit [23:0] raw);
        longint a;
        longint m;
        longint k;
        a = longint'(signed'(raw));
        m = a % longint'(mmb_pkg::TURN_UNITS);
        if (m < 0) begin
            m += mmb_pkg::TURN_UNITS;
        end
        k = (m * TRIG_DEPTH + mmb_pkg::TURN_UNITS / 2) / mmb_pkg::TURN_UNITS;
        if (k >= TRIG_DEPTH) begin
            k -= TRIG_DEPTH;
        end
        return int'(k);
    endfunction

    // round half up, i.e. floor((v + half) / 2^k)
    function automatic longint round_shift(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // build the expected rows of M = T * Ra * Rz * S
    task automatic predict_matrix(bit [159:0] req);
        int          kz;
        int          ka;
        longint      sz;
        longint      cz;
        longint      sa;
        longint      ca;
        longint      omc;
        longint      n[3];
        longint      sn[3];
        longint      skew[3][3];
        longint      rot[3][3];
        longint      q[3];
        longint      shift;
        longint      gain;
        matrix_row_t row;
        kz = table_slot(req[23:0]);
        ka = table_slot(req[47:24]);
        sz = sin_rom[kz];
        cz = cos_rom[kz];
        sa = sin_rom[ka];
        ca = cos_rom[ka];
        n[0] = longint'(signed'(req[63:48]));
        n[1] = longint'(signed'(req[79:64]));
        n[2] = longint'(signed'(req[95:80]));
        shift = longint'(signed'(req[127:96]));
        gain = longint'(signed'(req[159:128]));
        omc = 65536 - ca;
        for (int i = 0; i < 3; i++) begin
            sn[i] = round_shift(sa * n[i], 14);
        end
        skew = '{'{0, -sn[2], sn[1]}, '{sn[2], 0, -sn[0]}, '{-sn[1], sn[0], 0}};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rot[i][j] = ((i == j) ? ca : 0) + round_shift(omc * (n[i] * n[j]), 28)
                          + skew[i][j];
            end
        end
        for (int i = 0; i < 3; i++) begin
            q[0] = round_shift(rot[i][0] * cz + rot[i][1] * sz, 16);
            q[1] = round_shift(rot[i][1] * cz - rot[i][0] * sz, 16);
            q[2] = rot[i][2];
            row.val[0] = i;
            for (int c = 0; c < 3; c++) begin
                row.val[c + 1] = clamp32(round_shift(q[c] * gain, 16));
            end
            row.val[4] = (i == 0) ? shift : 0;
            row.val[5] = 0;
            rows_due.push_back(row);
        end
        row.val = '{3, 0, 0, 0, 65536, 1};
        rows_due.push_back(row);
    endtask

    initial begin
        for (int k = 0; k < TRIG_DEPTH; k++) begin
            sin_rom[k] = sine_at(32'((64'(k) << 32) / TRIG_DEPTH));
            cos_rom[k] = sine_at(32'((64'(k) << 32) / TRIG_DEPTH) + mmb_pkg::QUARTER_PHASE);
        end
    end

    assign pending = rows_due.size();

    // sample at the edge: values seen here are the ones the block sampled
    always @(posedge aclk) begin
        matrix_row_t want;
        longint      got[6];
        string       names[6];
        if (!aresetn) begin
            errors = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_matrix(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                names = '{"row_index", "col0", "col1", "col2", "col3", "last_row"};
                got[0] = m_tdata[1:0];
                got[1] = longint'(signed'(m_tdata[33:2]));
                got[2] = longint'(signed'(m_tdata[65:34]));
                got[3] = longint'(signed'(m_tdata[97:66]));
                got[4] = longint'(signed'(m_tdata[129:98]));
                got[5] = m_tlast;
                if (rows_due.size() == 0) begin
                    $display("%0t: unexpected row, actual row_index %0d", $time, got[0]);
                    errors++;
                end else begin
                    want = rows_due.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        if (want.val[f] != got[f]) begin
                            $display("%0t: %s mismatch, expected %0d actual %0d",
                                     $time, names[f], want.val[f], got[f]);
                            errors++;
                        end
                    end
                end
            end
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives matrix requests into the model matrix builder under several idle and
// stall mixes; the checker predicts and compares the rows, this top gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ONE = 65536;      // 1.0 in Q16.16
    localparam int UNIT = 16384;     // 1.0 in Q2.14
    localparam int DEG = 256;        // one degree in angle units
    localparam int RANDOM_PER_PHASE = 113;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tlast;
    int           errors;
    int           pending;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    always #6 aclk = ~aclk;

    model_matrix_builder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    model_matrix_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    // receiver: stall at random with the current phase's rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one request: idle at random first, then hold it until accepted.
    // Fields pack from the low bits: z_angle, axis_angle, axis_x, axis_y,
    // axis_z, shift_x, scale; each is cut to its field width here.
    task automatic send_request(int z_ang, int ax_ang, int ax, int ay, int az,
                                int shift, int gain);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {gain, shift, 16'(az), 16'(ay), 16'(ax), 24'(ax_ang), 24'(z_ang)};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Random request: mostly modest axes, scales and angles, some of them unit
    // axes; some full range noise so every bit of every field moves.
    task automatic send_random();
        int za;
        int aa;
        int n[3];
        int shift;
        int gain;
        int pick;
        pick = int'($urandom_range(9));
        za = (pick < 6) ? int'($urandom_range(2 * 720 * DEG)) - 720 * DEG : int'($urandom);
        aa = (pick < 6) ? int'($urandom_range(2 * 720 * DEG)) - 720 * DEG : int'($urandom);
        if (pick < 3) begin
            // axis-aligned unit axis with random sign
            n = '{0, 0, 0};
            n[$urandom_range(2)] = ($urandom_range(1) != 0) ? UNIT : -UNIT;
        end else if (pick < 8) begin
            for (int i = 0; i < 3; i++) begin
                n[i] = int'($urandom_range(2 * UNIT)) - UNIT;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                n[i] = int'($urandom);
            end
        end
        shift = int'($urandom);
        gain = (pick < 8) ? int'($urandom_range(8 * ONE)) - 4 * ONE : int'($urandom);
        send_request(za, aa, n[0], n[1], n[2], shift, gain);
    endtask

    // hold the sender back until every expected row has come
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: quarter turns, negative and extreme angles, unit axes
        send_request(0, 0, UNIT, 0, 0, 0, ONE);
        send_request(90 * DEG, 0, 0, 0, UNIT, 0, ONE);
        send_request(0, 90 * DEG, UNIT, 0, 0, 0, ONE);
        send_request(180 * DEG, 180 * DEG, 0, UNIT, 0, ONE, ONE);
        send_request(270 * DEG, 270 * DEG, 0, 0, UNIT, -ONE, ONE);
        send_request(-90 * DEG, -45 * DEG, 0, -UNIT, 0, 0, ONE);
        send_request('h7F_FFFF, 'h80_0000, 0, 0, -UNIT, 0, ONE);
        send_request('h80_0000, 'h7F_FFFF, -UNIT, 0, 0, 0, 2 * ONE);
        send_request(360 * DEG, -360 * DEG, UNIT, 0, 0, 0, ONE);
        send_request(359 * DEG + 255, 128, 9459, 9459, 9459, 3 * ONE, ONE / 2);
        // non-unit axes: applied as is; the second, at full scale, saturates
        send_request(30 * DEG, 60 * DEG, 'h7FFF, 'h7FFF, 'h7FFF, 0, ONE);
        send_request(45 * DEG, 120 * DEG, 'h8000, 'h8000, 'h8000, 0, 32'h7FFF_FFFF);
        // scale extremes and negative scale
        send_request(10 * DEG, 20 * DEG, UNIT, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(10 * DEG, 20 * DEG, 0, UNIT, 0, 32'h8000_0000, 32'h8000_0000);
        send_request(0, 0, 0, 0, UNIT, 0, -ONE);
        send_request(33 * DEG, 77 * DEG, 0, 0, 0, 12345, 0);
        send_request('hFF_FFFF, 1, 'hFFFF, 1, 0, 32'hFFFF_FFFF, 1);
        send_request(-1 * DEG, 1 * DEG, UNIT, 0, 0, -1, -1);
        drain();

        // random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 51 : (ph == 3) ? 24 : 0;
            recv_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 24 : 0;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                send_random();
            end
            drain();
        end

        recv_stall_pct = 0;
        repeat (40) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // watchdog for a hung handshake
    initial begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
